>>> design/bpe_pkg.sv
// Shared types and constants for the Bezier point evaluator.
`timescale 1ns / 1ps

package bpe_pkg;

  // Request kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_EVAL   = 2'd2;

  // Result status
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Curve parameter, unsigned Q0.16 with one extra bit for the value one
  localparam int unsigned T_WIDTH = 17;
  localparam int unsigned T_FRAC  = 16;
  localparam logic [T_WIDTH-1:0] T_ONE = 17'h10000;
  localparam int unsigned ROUND_HALF = 32768;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD0 = 6'b000010,
    S_PREV  = 6'b000100,
    S_MUL   = 6'b001000,
    S_SUM   = 6'b010000,
    S_EMIT  = 6'b100000
  } bpe_state_t;

endpackage

>>> design/bpe_store.sv
// Control point memory and interpolation scratch memory with a shared read path.
`timescale 1ns / 1ps

module bpe_store #(
  parameter int MAX_POINTS  = 16,
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          ctrl_wr_en,
  input  logic [$clog2(MAX_POINTS)-1:0] ctrl_wr_addr,
  input  logic [2*COORD_WIDTH-1:0]      ctrl_wr_data,
  input  logic                          work_wr_en,
  input  logic [$clog2(MAX_POINTS)-1:0] work_wr_addr,
  input  logic [2*COORD_WIDTH-1:0]      work_wr_data,
  input  logic                          rd_en,
  input  logic                          rd_src_ctrl,
  input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  output logic [2*COORD_WIDTH-1:0]      rd_data
);

  localparam int DW = 2 * COORD_WIDTH;

  logic [DW-1:0] ctrl_mem [MAX_POINTS];
  logic [DW-1:0] work_mem [MAX_POINTS];
  logic [DW-1:0] ctrl_rd;
  logic [DW-1:0] work_rd;
  logic          src_ctrl;

  always_ff @(posedge clk) begin
    if (ctrl_wr_en) begin
      ctrl_mem[ctrl_wr_addr] <= ctrl_wr_data;
    end
    if (rd_en) begin
      ctrl_rd <= ctrl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (work_wr_en) begin
      work_mem[work_wr_addr] <= work_wr_data;
    end
    if (rd_en) begin
      work_rd  <= work_mem[rd_addr];
      src_ctrl <= rd_src_ctrl;
    end
  end

  assign rd_data = src_ctrl ? ctrl_rd : work_rd;

endmodule

>>> design/bpe_lerp.sv
// Shared interpolation unit: one multiplier per coordinate, then a rounding add.
`timescale 1ns / 1ps

module bpe_lerp #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          mul_en,
  input  logic [bpe_pkg::T_WIDTH-1:0]   t_val,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  output logic signed [COORD_WIDTH-1:0] v_x,
  output logic signed [COORD_WIDTH-1:0] v_y
);

  // difference is COORD_WIDTH+1 bits, t is made signed with one more bit
  localparam int PW = COORD_WIDTH + 1 + bpe_pkg::T_WIDTH + 1;
  localparam int SW = PW - bpe_pkg::T_FRAC;

  logic signed [COORD_WIDTH:0]       diff_x;
  logic signed [COORD_WIDTH:0]       diff_y;
  logic signed [bpe_pkg::T_WIDTH:0]  t_s;
  logic signed [PW-1:0]              prod_x;
  logic signed [PW-1:0]              prod_y;
  logic signed [COORD_WIDTH-1:0]     base_x;
  logic signed [COORD_WIDTH-1:0]     base_y;
  logic signed [PW-1:0]              biased_x;
  logic signed [PW-1:0]              biased_y;
  logic signed [SW-1:0]              sum_x;
  logic signed [SW-1:0]              sum_y;

  assign diff_x = {b_x[COORD_WIDTH-1], b_x} - {a_x[COORD_WIDTH-1], a_x};
  assign diff_y = {b_y[COORD_WIDTH-1], b_y} - {a_y[COORD_WIDTH-1], a_y};
  assign t_s    = {1'b0, t_val};

  // a + t*(b-a) rounded half up; 65536*a carries no fraction, so add a afterwards
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_x <= PW'(diff_x * t_s);
      prod_y <= PW'(diff_y * t_s);
      base_x <= a_x;
      base_y <= a_y;
    end
  end

  assign biased_x = prod_x + PW'(bpe_pkg::ROUND_HALF);
  assign biased_y = prod_y + PW'(bpe_pkg::ROUND_HALF);
  assign sum_x = biased_x[PW-1:bpe_pkg::T_FRAC] + SW'(base_x);
  assign sum_y = biased_y[PW-1:bpe_pkg::T_FRAC] + SW'(base_y);
  assign v_x = sum_x[COORD_WIDTH-1:0];
  assign v_y = sum_y[COORD_WIDTH-1:0];

endmodule

>>> design/bezier_point_evaluator_core.sv
// Top level of the Bezier point evaluator: request decode and interpolation sequencer.
`timescale 1ns / 1ps

// Requests clear the control point list, append a point (dropped when the list
// is full) or evaluate the curve at t by de Casteljau. Clear and append give no
// result. An evaluate over n stored points runs n-1 levels of pairwise
// interpolation through one shared multiplier pair and a scratch memory with one
// registered read port: each level primes the read path in the LOAD0 and PREV
// states and then passes through MUL and SUM once per interpolation, and the
// request ends in the EMIT state, which offers the result. A stalled earlier
// result holds the block in EMIT until it is taken. An empty list gives status 1
// with zero coordinates.
// The result register frees the input side once the result is loaded.
module bezier_point_evaluator_core #(
  parameter int MAX_POINTS  = 16,
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    kind,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic [bpe_pkg::T_WIDTH-1:0]   t_param,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] curve_x,
  output logic signed [COORD_WIDTH-1:0] curve_y,
  output logic                          status
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = 2 * COORD_WIDTH;

  bpe_pkg::bpe_state_t state;

  logic [CW-1:0]                 count;
  logic [CW-1:0]                 lerps;
  logic [CW-1:0]                 j;
  logic [CW-1:0]                 j_inc1;
  logic [CW-1:0]                 j_inc2;
  logic                          src_ctrl;
  logic [bpe_pkg::T_WIDTH-1:0]   t_reg;
  logic signed [COORD_WIDTH-1:0] prev_x;
  logic signed [COORD_WIDTH-1:0] prev_y;
  logic signed [COORD_WIDTH-1:0] res_x;
  logic signed [COORD_WIDTH-1:0] res_y;
  logic                          res_status;

  logic                          accept;
  logic                          out_free;
  logic                          out_valid_next;
  logic                          more;
  logic                          ctrl_wr_en;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [DW-1:0]                 rd_data;
  logic signed [COORD_WIDTH-1:0] cur_x;
  logic signed [COORD_WIDTH-1:0] cur_y;
  logic signed [COORD_WIDTH-1:0] v_x;
  logic signed [COORD_WIDTH-1:0] v_y;

  assign in_stall = (state != bpe_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign j_inc1   = j + CW'(1);
  assign j_inc2   = j + CW'(2);
  assign more     = (j_inc1 < lerps);
  assign cur_x    = rd_data[DW-1:COORD_WIDTH];
  assign cur_y    = rd_data[COORD_WIDTH-1:0];

  // hold a stalled result, load a new one from the emit state
  assign out_valid_next = ((state == bpe_pkg::S_EMIT) && out_free) || (out_valid && out_stall);

  assign ctrl_wr_en = accept && (kind == bpe_pkg::KIND_APPEND) && (count < CW'(MAX_POINTS));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      bpe_pkg::S_LOAD0: begin
        rd_en = 1'b1;
      end
      bpe_pkg::S_PREV: begin
        rd_en   = (lerps != '0);
        rd_addr = j_inc1[AW-1:0];
      end
      bpe_pkg::S_MUL: begin
        // fetch the right operand of the next interpolation ahead of time
        rd_en   = more;
        rd_addr = j_inc2[AW-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  bpe_store #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_store (
    .clk         (clk),
    .ctrl_wr_en  (ctrl_wr_en),
    .ctrl_wr_addr(count[AW-1:0]),
    .ctrl_wr_data({point_x, point_y}),
    .work_wr_en  (state == bpe_pkg::S_SUM),
    .work_wr_addr(j[AW-1:0]),
    .work_wr_data({v_x, v_y}),
    .rd_en       (rd_en),
    .rd_src_ctrl (src_ctrl),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  bpe_lerp #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_lerp (
    .clk   (clk),
    .mul_en(state == bpe_pkg::S_MUL),
    .t_val (t_reg),
    .a_x   (prev_x),
    .a_y   (prev_y),
    .b_x   (cur_x),
    .b_y   (cur_y),
    .v_x   (v_x),
    .v_y   (v_y)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpe_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        bpe_pkg::S_IDLE: begin
          if (accept) begin
            case (kind)
              bpe_pkg::KIND_CLEAR: begin
                count <= '0;
              end
              bpe_pkg::KIND_APPEND: begin
                if (ctrl_wr_en) begin
                  count <= count + CW'(1);
                end
              end
              bpe_pkg::KIND_EVAL: begin
                state <= (count == '0) ? bpe_pkg::S_EMIT : bpe_pkg::S_LOAD0;
              end
              default: begin
                state <= bpe_pkg::S_IDLE;
              end
            endcase
          end
        end
        bpe_pkg::S_LOAD0: begin
          state <= bpe_pkg::S_PREV;
        end
        bpe_pkg::S_PREV: begin
          state <= (lerps == '0) ? bpe_pkg::S_EMIT : bpe_pkg::S_MUL;
        end
        bpe_pkg::S_MUL: begin
          state <= bpe_pkg::S_SUM;
        end
        bpe_pkg::S_SUM: begin
          if (more) begin
            state <= bpe_pkg::S_MUL;
          end else if (lerps == CW'(1)) begin
            state <= bpe_pkg::S_EMIT;
          end else begin
            state <= bpe_pkg::S_LOAD0;
          end
        end
        bpe_pkg::S_EMIT: begin
          if (out_free) begin
            state <= bpe_pkg::S_IDLE;
          end
        end
        default: begin
          state <= bpe_pkg::S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      bpe_pkg::S_IDLE: begin
        if (accept && (kind == bpe_pkg::KIND_EVAL)) begin
          t_reg      <= (t_param > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : t_param;
          lerps      <= count - CW'(1);
          src_ctrl   <= 1'b1;
          res_x      <= '0;
          res_y      <= '0;
          res_status <= (count == '0) ? bpe_pkg::STATUS_EMPTY : bpe_pkg::STATUS_OK;
        end
      end
      bpe_pkg::S_LOAD0: begin
        j <= '0;
      end
      bpe_pkg::S_PREV: begin
        prev_x <= cur_x;
        prev_y <= cur_y;
        // a single point is its own curve
        if (lerps == '0) begin
          res_x <= cur_x;
          res_y <= cur_y;
        end
      end
      bpe_pkg::S_MUL: begin
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
      bpe_pkg::S_SUM: begin
        if (more) begin
          j <= j_inc1;
        end else begin
          // level done: later levels read back the scratch memory
          lerps    <= lerps - CW'(1);
          src_ctrl <= 1'b0;
          res_x    <= v_x;
          res_y    <= v_y;
        end
      end
      bpe_pkg::S_EMIT: begin
        if (out_free) begin
          curve_x <= res_x;
          curve_y <= res_y;
          status  <= res_status;
        end
      end
      default: begin
        j <= j;
      end
    endcase
  end

endmodule

>>> design/bpe_checker.sv
// Port-level assertions for the Bezier point evaluator and their binding.
`timescale 1ns / 1ps

module bpe_checker #(
  parameter int COORD_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic [1:0]             kind,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [COORD_WIDTH-1:0] curve_x,
  input logic [COORD_WIDTH-1:0] curve_y,
  input logic                   status
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(curve_x) && $stable(curve_y) &&
      $stable(status))
  else $error("stalled result changed or dropped");

  // an empty list reports zero coordinates
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == bpe_pkg::STATUS_EMPTY) |-> (curve_x == '0) && (curve_y == '0))
  else $error("empty status with nonzero coordinates");

  // an evaluate request keeps the block busy in the following cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (kind == bpe_pkg::KIND_EVAL) |=> in_stall)
  else $error("block ready right after an evaluate request");

  // a new result only appears at the end of a busy period
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
  else $error("result appeared without a busy evaluation");

endmodule

bind bezier_point_evaluator_core bpe_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_bpe_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .kind     (kind),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .curve_x  (curve_x),
  .curve_y  (curve_y),
  .status   (status)
);
